>>> hdl/obd_pkg.sv
// Shared types, codes and tables of the OBD-II PID poll sequencer.
`timescale 1ns / 1ps
`default_nettype none
package obd_pkg;

    localparam int OBD_QUEUE_DEPTH = 4;
    localparam int NUM_PIDS        = 5;

    localparam int ID_W    = 29;
    localparam int TICK_W  = 16;
    localparam int VALUE_W = 17;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 64;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [7:0] MODE01_RESPONSE = 8'h41;
    localparam logic [7:0] COOLANT_OFFSET  = 8'd40;

    localparam logic [ID_W-1:0]   REQ_ID_RESET  = 29'd2015;
    localparam logic [ID_W-1:0]   RSP_MIN_RESET = 29'd2024;
    localparam logic [ID_W-1:0]   RSP_MAX_RESET = 29'd2031;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;

    typedef enum logic [1:0] {
        REG_REQ_ID  = 2'd0,
        REG_RSP_MIN = 2'd1,
        REG_RSP_MAX = 2'd2,
        REG_TIMEOUT = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_FRAME = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_UPDATE  = 2'd1,
        KIND_DONE    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        QTY_RPM     = 3'd0,
        QTY_SPEED   = 3'd1,
        QTY_COOLANT = 3'd2,
        QTY_BATTERY = 3'd3,
        QTY_MIL     = 3'd4
    } quantity_t;

    typedef struct packed {
        logic [ID_W-1:0]   request_frame_id;
        logic [ID_W-1:0]   response_id_min;
        logic [ID_W-1:0]   response_id_max;
        logic [TICK_W-1:0] timeout_ticks;
    } obd_cfg_t;

    typedef struct packed {
        kind_t                     kind;
        logic [7:0]                req_pid;
        logic [2:0]                quantity;
        logic signed [VALUE_W-1:0] value;
        logic                      round_valid;
        logic                      last;
    } obd_entry_t;

    // Poll order; indexes past the end map to the last PID.
    function automatic logic [7:0] pid_order(input logic [2:0] idx);
        logic [7:0] pid;
        case (idx)
            3'd0:    pid = 8'h0C;
            3'd1:    pid = 8'h0D;
            3'd2:    pid = 8'h05;
            3'd3:    pid = 8'h42;
            default: pid = 8'h01;
        endcase
        return pid;
    endfunction

endpackage
`default_nettype wire

>>> hdl/obd2_pid_poll_sequencer.sv
// Top level: OBD-II mode 01 PID poll sequencer with APB registers.
//
// Input channel s_*: tuser selects the item (start round, 1 ms tick, received
// CAN frame); tdata carries the frame fields. A start while idle emits the
// first request; requests go out on m_* with kind 0, decoded values with
// kind 1 and the end of a round with kind 2. tlast marks the final result of
// each input transfer.
// Results pass the queue and the output register. Throughput: one input
// transfer per cycle while results drain; a success yields two results, and
// the result channel moves one per cycle while m_tready is high. The result
// queue between front and back end sets how far input can run ahead: s_tready
// is low while fewer than two queue slots are free, so a stalled receiver
// backs up into the input channel without losing results.
// Reset (aresetn low, synchronous) returns to idle, empties the queue and
// loads the register defaults. The user must write registers over APB only
// while the block is idle (not enforced by the block); pready is always high.
`timescale 1ns / 1ps
`default_nettype none
module obd2_pid_poll_sequencer #(
    parameter int QUEUE_DEPTH = obd_pkg::OBD_QUEUE_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // APB register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [obd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [obd_pkg::PDATA_W-1:0]   pwdata,
    output logic [obd_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    // input: frame_id[28:0] frame_len[32:29] length_byte[40:33] mode_byte[48:41]
    //        pid_byte[56:49] byte_a[64:57] byte_b[72:65], zero pad
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [obd_pkg::S_TDATA_W-1:0] s_tdata,
    // input user: func[1:0]
    input  wire logic [1:0]                    s_tuser,
    // output: req_id[28:0] req_pid[36:29] quantity[39:37] value[56:40]
    //         round_valid[57], zero pad
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [obd_pkg::M_TDATA_W-1:0]      m_tdata,
    // output user: kind[1:0]
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);
    import obd_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    obd_cfg_t   cfg_reg;
    logic       cfg_we;
    reg_index_t reg_idx;
    logic [1:0] push_n;
    obd_entry_t ent0, ent1, q_head;
    logic       q_valid, pop, room;
    logic [CW-1:0] q_count;

    assign pready  = 1'b1;
    assign reg_idx = reg_index_t'(paddr[3:2]);
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.request_frame_id <= REQ_ID_RESET;
            cfg_reg.response_id_min  <= RSP_MIN_RESET;
            cfg_reg.response_id_max  <= RSP_MAX_RESET;
            cfg_reg.timeout_ticks    <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (reg_idx)
                REG_REQ_ID:  cfg_reg.request_frame_id <= pwdata[ID_W-1:0];
                REG_RSP_MIN: cfg_reg.response_id_min  <= pwdata[ID_W-1:0];
                REG_RSP_MAX: cfg_reg.response_id_max  <= pwdata[ID_W-1:0];
                REG_TIMEOUT: cfg_reg.timeout_ticks    <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_REQ_ID:  prdata = PDATA_W'(cfg_reg.request_frame_id);
            REG_RSP_MIN: prdata = PDATA_W'(cfg_reg.response_id_min);
            REG_RSP_MAX: prdata = PDATA_W'(cfg_reg.response_id_max);
            REG_TIMEOUT: prdata = PDATA_W'(cfg_reg.timeout_ticks);
            default:     prdata = '0;
        endcase
    end

    assign room = q_count <= CW'(QUEUE_DEPTH - 2);

    obd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .room     (room),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push_n   (push_n),
        .ent0     (ent0),
        .ent1     (ent1)
    );

    obd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_n  (push_n),
        .ent0    (ent0),
        .ent1    (ent1),
        .pop     (pop),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_count (q_count)
    );

    obd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .request_frame_id (cfg_reg.request_frame_id),
        .q_valid          (q_valid),
        .q_head           (q_head),
        .pop              (pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_no_push_without_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n != 2'd0) |-> room)
        else $error("queue written without two free slots");

    a_update_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_UPDATE) |-> !m_tlast)
        else $error("value update marked last");

    a_other_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_UPDATE) |-> (m_tlast && m_tuser != 2'd3))
        else $error("request or done result not last, or bad kind");

endmodule
`default_nettype wire

>>> hdl/obd_front.sv
// Front end: accepts input transfers, runs the poll round and emits queue entries.
`timescale 1ns / 1ps
`default_nettype none
module obd_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire obd_pkg::obd_cfg_t             cfg,
    input  wire logic                          room,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [obd_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]                    s_tuser,
    output logic [1:0]                         push_n,
    output obd_pkg::obd_entry_t                ent0,
    output obd_pkg::obd_entry_t                ent1
);
    import obd_pkg::*;

    logic              busy_reg, busy_next;
    logic [2:0]        pid_index_reg, pid_index_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic              any_success_reg, any_success_next;

    logic              accept;
    logic [ID_W-1:0]   fid;
    logic [3:0]        flen;
    logic [7:0]        lenb, mode, pidb, byte_a, byte_b, b_eff;
    logic [15:0]       ab;
    logic [TICK_W-1:0] e1;
    logic [2:0]        nidx;
    logic              match;
    logic signed [VALUE_W-1:0] val;

    function automatic obd_entry_t adv_entry(input logic [2:0] idx, input logic any);
        obd_entry_t e;
        e = '0;
        e.last = 1'b1;
        if (idx >= 3'(NUM_PIDS)) begin
            e.kind        = KIND_DONE;
            e.round_valid = any;
        end else begin
            e.kind    = KIND_REQUEST;
            e.req_pid = pid_order(idx);
        end
        return e;
    endfunction

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    assign fid    = s_tdata[28:0];
    assign flen   = s_tdata[32:29];
    assign lenb   = s_tdata[40:33];
    assign mode   = s_tdata[48:41];
    assign pidb   = s_tdata[56:49];
    assign byte_a = s_tdata[64:57];
    assign byte_b = s_tdata[72:65];
    assign b_eff  = (flen < 4'd5) ? 8'd0 : byte_b;
    assign ab     = {byte_a, b_eff};
    assign e1     = elapsed_reg + 16'd1;
    assign nidx   = pid_index_reg + 3'd1;

    assign match = (fid >= cfg.response_id_min) && (fid <= cfg.response_id_max) &&
                   (flen >= 4'd4) && (mode == MODE01_RESPONSE) &&
                   (pidb == pid_order(pid_index_reg));

    always_comb begin
        case (pid_index_reg)
            QTY_RPM:     val = VALUE_W'(ab >> 2);
            QTY_SPEED:   val = VALUE_W'(byte_a);
            QTY_COOLANT: val = VALUE_W'(byte_a) - VALUE_W'(COOLANT_OFFSET);
            QTY_BATTERY: val = VALUE_W'(ab);
            default:     val = VALUE_W'(byte_a[7]);
        endcase
    end

    always_comb begin
        busy_next        = busy_reg;
        pid_index_next   = pid_index_reg;
        elapsed_next     = elapsed_reg;
        any_success_next = any_success_reg;
        push_n           = 2'd0;
        ent0             = '0;
        ent1             = '0;
        if (accept) begin
            case (func_t'(s_tuser))
                FUNC_START: begin
                    if (!busy_reg) begin
                        busy_next        = 1'b1;
                        pid_index_next   = 3'd0;
                        elapsed_next     = '0;
                        any_success_next = 1'b0;
                        push_n           = 2'd1;
                        ent0             = adv_entry(3'd0, 1'b0);
                    end
                end
                FUNC_TICK: begin
                    if (busy_reg) begin
                        if (e1 == '0 || e1 >= cfg.timeout_ticks) begin
                            pid_index_next = nidx;
                            elapsed_next   = '0;
                            busy_next      = nidx < 3'(NUM_PIDS);
                            push_n         = 2'd1;
                            ent0           = adv_entry(nidx, any_success_reg);
                        end else begin
                            elapsed_next = e1;
                        end
                    end
                end
                FUNC_FRAME: begin
                    if (busy_reg && match) begin
                        pid_index_next = nidx;
                        elapsed_next   = '0;
                        busy_next      = nidx < 3'(NUM_PIDS);
                        if (lenb <= 8'd2) begin
                            push_n = 2'd1;
                            ent0   = adv_entry(nidx, any_success_reg);
                        end else begin
                            if (pid_index_reg == QTY_RPM || pid_index_reg == QTY_SPEED) begin
                                any_success_next = 1'b1;
                            end
                            push_n        = 2'd2;
                            ent0.kind     = KIND_UPDATE;
                            ent0.quantity = pid_index_reg;
                            ent0.value    = val;
                            ent1          = adv_entry(nidx, any_success_next);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            pid_index_reg   <= 3'd0;
            elapsed_reg     <= '0;
            any_success_reg <= 1'b0;
        end else begin
            busy_reg        <= busy_next;
            pid_index_reg   <= pid_index_next;
            elapsed_reg     <= elapsed_next;
            any_success_reg <= any_success_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/obd_queue.sv
// Short result queue between front and back, up to two writes and one read per cycle.
`timescale 1ns / 1ps
`default_nettype none
module obd_queue #(
    parameter int DEPTH = obd_pkg::OBD_QUEUE_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [1:0]                 push_n,
    input  wire obd_pkg::obd_entry_t        ent0,
    input  wire obd_pkg::obd_entry_t        ent1,
    input  wire logic                       pop,
    output logic                            q_valid,
    output obd_pkg::obd_entry_t             q_head,
    output logic [$clog2(DEPTH+1)-1:0]      q_count
);
    import obd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    obd_entry_t     mem [DEPTH];
    logic [PW-1:0]  wr_reg, wr_next, wr1, rd_reg, rd_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_pop;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign do_pop     = pop && (count_reg != '0);
    assign wr1        = inc(wr_reg);
    assign wr_next    = (push_n == 2'd2) ? inc(wr1) : (push_n == 2'd1) ? wr1 : wr_reg;
    assign rd_next    = do_pop ? inc(rd_reg) : rd_reg;
    assign count_next = count_reg + CW'(push_n) - CW'(do_pop);

    assign q_valid = count_reg != '0;
    assign q_head  = mem[rd_reg];
    assign q_count = count_reg;

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wr_reg] <= ent0;
        end
        if (push_n == 2'd2) begin
            mem[wr1] <= ent1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/obd_back.sv
// Back end: drains the queue into the registered result channel.
`timescale 1ns / 1ps
`default_nettype none
module obd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [obd_pkg::ID_W-1:0]      request_frame_id,
    input  wire logic                          q_valid,
    input  wire obd_pkg::obd_entry_t           q_head,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [obd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);
    import obd_pkg::*;

    logic                      valid_reg;
    kind_t                     kind_reg;
    logic [ID_W-1:0]           req_id_reg;
    logic [7:0]                req_pid_reg;
    logic [2:0]                quantity_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      round_valid_reg;
    logic                      last_reg;

    assign pop = q_valid && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg        <= q_head.kind;
            req_id_reg      <= (q_head.kind == KIND_REQUEST) ? request_frame_id : '0;
            req_pid_reg     <= q_head.req_pid;
            quantity_reg    <= q_head.quantity;
            value_reg       <= q_head.value;
            round_valid_reg <= q_head.round_valid;
            last_reg        <= q_head.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'd0, round_valid_reg, value_reg, quantity_reg, req_pid_reg,
                       req_id_reg};

endmodule
`default_nettype wire

>>> tb/obd_poll_scoreboard.sv
// Scoreboard package: frame type and the predictor/checker of the OBD-II PID poll sequencer.
`timescale 1ns / 1ps
package obd_tb_pkg;
    import obd_pkg::*;

    localparam logic [1:0]      FUNC_UNUSED = 2'd3;
    localparam logic [ID_W-1:0] ID_MAX      = 29'h1FFF_FFFF;
    // poll order, first PID in the low byte
    localparam logic [39:0]     POLL_PIDS   = {8'h01, 8'h42, 8'h05, 8'h0D, 8'h0C};

    // packed in s_tdata order, frame_id in the low bits
    typedef struct packed {
        logic [7:0]      b;
        logic [7:0]      a;
        logic [7:0]      pid;
        logic [7:0]      mode;
        logic [7:0]      lenb;
        logic [3:0]      len;
        logic [ID_W-1:0] id;
    } can_frame_t;

    typedef struct {
        kind_t                     kind;
        logic [ID_W-1:0]           req_id;
        logic [7:0]                req_pid;
        quantity_t                 quantity;
        logic signed [VALUE_W-1:0] value;
        logic                      round_valid;
        logic                      last;
    } poll_result_t;

    class poll_scoreboard;
        obd_cfg_t          cfg;
        bit                busy;
        logic [2:0]        pid_index;
        logic [TICK_W-1:0] elapsed;
        bit                any_success;
        poll_result_t      pending_q[$];
        int unsigned       n_errors;
        int unsigned       n_checked;
        int unsigned       n_rounds;
        int unsigned       n_updates;

        function new();
            cfg.request_frame_id = REQ_ID_RESET;
            cfg.response_id_min  = RSP_MIN_RESET;
            cfg.response_id_max  = RSP_MAX_RESET;
            cfg.timeout_ticks    = TIMEOUT_RESET;
            busy        = 0;
            pid_index   = '0;
            elapsed     = '0;
            any_success = 0;
        endfunction

        function void set_config(reg_index_t idx, logic [31:0] v);
            case (idx)
                REG_REQ_ID:  cfg.request_frame_id = v[ID_W-1:0];
                REG_RSP_MIN: cfg.response_id_min  = v[ID_W-1:0];
                REG_RSP_MAX: cfg.response_id_max  = v[ID_W-1:0];
                REG_TIMEOUT: cfg.timeout_ticks    = v[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [2:0] active_index();
            return (pid_index >= NUM_PIDS) ? 3'(NUM_PIDS - 1) : pid_index;
        endfunction

        function logic [7:0] awaited_pid();
            return POLL_PIDS[active_index()*8 +: 8];
        endfunction

        function void push_request();
            poll_result_t r;
            r.kind        = KIND_REQUEST;
            r.req_id      = cfg.request_frame_id;
            r.req_pid     = awaited_pid();
            r.quantity    = QTY_RPM;
            r.value       = '0;
            r.round_valid = 1'b0;
            r.last        = 1'b1;
            pending_q.push_back(r);
        endfunction

        function void next_pid();
            poll_result_t r;
            pid_index = pid_index + 3'd1;
            elapsed   = '0;
            if (pid_index >= NUM_PIDS) begin
                busy          = 0;
                r.kind        = KIND_DONE;
                r.req_id      = '0;
                r.req_pid     = '0;
                r.quantity    = QTY_RPM;
                r.value       = '0;
                r.round_valid = any_success;
                r.last        = 1'b1;
                pending_q.push_back(r);
            end else begin
                push_request();
            end
        endfunction

        // Returns 1 when the transfer was not ignored.
        function bit note_input(logic [1:0] func, can_frame_t f);
            quantity_t    qty;
            logic [7:0]   b;
            logic [15:0]  ab;
            poll_result_t r;
            if (func == FUNC_START) begin
                if (busy)
                    return 0;
                busy        = 1;
                pid_index   = '0;
                elapsed     = '0;
                any_success = 0;
                n_rounds++;
                push_request();
                return 1;
            end
            if (!busy || func == FUNC_UNUSED)
                return 0;
            if (func == FUNC_TICK) begin
                elapsed = elapsed + 1'b1;
                if (elapsed == 0 || elapsed >= cfg.timeout_ticks)
                    next_pid();
                return 1;
            end
            if (f.id < cfg.response_id_min || f.id > cfg.response_id_max || f.len < 4
                    || f.mode != MODE01_RESPONSE || f.pid != awaited_pid())
                return 0;
            if (f.lenb <= 2) begin
                next_pid();
                return 1;
            end
            b   = (f.len < 5) ? 8'd0 : f.b;
            ab  = {f.a, b};
            qty = quantity_t'(active_index());
            case (qty)
                QTY_RPM: begin
                    r.value     = $signed({1'b0, ab >> 2});
                    any_success = 1;
                end
                QTY_SPEED: begin
                    r.value     = $signed({9'd0, f.a});
                    any_success = 1;
                end
                QTY_COOLANT: r.value = $signed({9'd0, f.a}) - 17'sd40;
                QTY_BATTERY: r.value = $signed({1'b0, ab});
                default:     r.value = $signed({16'd0, f.a[7]});
            endcase
            r.kind        = KIND_UPDATE;
            r.req_id      = '0;
            r.req_pid     = '0;
            r.quantity    = qty;
            r.round_valid = 1'b0;
            r.last        = 1'b0;
            pending_q.push_back(r);
            n_updates++;
            next_pid();
            return 1;
        endfunction

        function void compare(string field, longint expd, longint act);
            if (expd != act) begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: %s mismatch: expected %0d, got %0d",
                             $time, field, expd, act);
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [63:0] data, logic last);
            poll_result_t r;
            n_checked++;
            if (pending_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: unexpected result: expected none, got kind %0d data %h",
                             $time, kind, data);
                return;
            end
            r = pending_q.pop_front();
            compare("kind", r.kind, kind);
            compare("req_id", r.req_id, data[28:0]);
            compare("req_pid", r.req_pid, data[36:29]);
            compare("quantity", r.quantity, data[39:37]);
            compare("value", r.value, $signed(data[56:40]));
            compare("round_valid", r.round_valid, data[57]);
            compare("last", r.last, last);
        endfunction
    endclass

endpackage

>>> tb/tb_top.sv
// Testbench top: drives the poll sequencer over APB and streams, checks results on the fly.
`timescale 1ns / 1ps
module tb_top;
    import obd_pkg::*;
    import obd_tb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // frame_id, frame_len, length_byte, mode_byte, pid_byte, byte_a, byte_b, zero pad
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // func
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // req_id, req_pid, quantity, value, round_valid, zero pad
    logic [M_TDATA_W-1:0] m_tdata;
    // kind
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    poll_scoreboard sb = new();
    int unsigned    send_idle_pct = 0;
    int unsigned    stall_pct     = 0;
    int unsigned    n_sent        = 0;
    int unsigned    cycles        = 0;

    always #6 aclk = ~aclk;

    obd2_pid_poll_sequencer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run timed out, %0d results outstanding", $time, sb.pending_q.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic apb_write(reg_index_t idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_config(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(logic [ID_W-1:0] req_id, logic [ID_W-1:0] id_lo,
                                logic [ID_W-1:0] id_hi, logic [TICK_W-1:0] ticks);
        apb_write(REG_REQ_ID, {3'd0, req_id});
        apb_write(REG_RSP_MIN, {3'd0, id_lo});
        apb_write(REG_RSP_MAX, {3'd0, id_hi});
        apb_write(REG_TIMEOUT, {16'd0, ticks});
    endtask

    // leaves s_tvalid high after the transfer; caller lowers it when done
    task automatic send_item(logic [1:0] func, can_frame_t f, output bit taken);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'd0, f};
        do @(posedge aclk); while (!s_tready);
        taken = sb.note_input(func, f);
        n_sent++;
    endtask

    task automatic send_cmd(logic [1:0] func);
        bit taken;
        can_frame_t f;
        f = '0;
        send_item(func, f, taken);
    endtask

    task automatic send_frame(logic [ID_W-1:0] id, logic [3:0] len, logic [7:0] lenb,
                              logic [7:0] mode, logic [7:0] pid, logic [7:0] a, logic [7:0] b);
        bit taken;
        can_frame_t f;
        f = '{b: b, a: a, pid: pid, mode: mode, lenb: lenb, len: len, id: id};
        send_item(FUNC_FRAME, f, taken);
    endtask

    function automatic logic [ID_W-1:0] answer_id();
        if (sb.cfg.response_id_min <= sb.cfg.response_id_max)
            return ID_W'($urandom_range(sb.cfg.response_id_max, sb.cfg.response_id_min));
        return ID_W'($urandom);
    endfunction

    task automatic random_item(output logic [1:0] func, output can_frame_t f);
        int unsigned pick;
        f    = can_frame_t'($bits(can_frame_t)'({$urandom, $urandom, $urandom}));
        pick = $urandom_range(99);
        if (!sb.busy) begin
            func = (pick < 70) ? FUNC_START : 2'($urandom_range(3));
        end else if (pick < 55) begin
            func   = FUNC_FRAME;
            f.id   = answer_id();
            f.len  = (pick < 6) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 4));
            f.mode = MODE01_RESPONSE;
            f.pid  = sb.awaited_pid();
            f.lenb = ($urandom_range(9) == 0) ? 8'($urandom_range(2)) : 8'($urandom_range(255, 3));
        end else if (pick < 77) begin
            func = FUNC_TICK;
        end else if (pick < 92) begin
            func   = FUNC_FRAME;
            f.id   = answer_id();
            f.len  = 4'($urandom_range(8, 4));
            f.mode = MODE01_RESPONSE;
            f.pid  = sb.awaited_pid();
            case ($urandom_range(4))
                0: begin
                    if (sb.cfg.response_id_min > 0)
                        f.id = ID_W'($urandom_range(sb.cfg.response_id_min - 1));
                    else if (sb.cfg.response_id_max < ID_MAX)
                        f.id = ID_W'($urandom_range(ID_MAX, sb.cfg.response_id_max + 1));
                end
                1: f.len  = 4'($urandom_range(3));
                2: f.mode = MODE01_RESPONSE ^ 8'($urandom_range(255, 1));
                3: f.pid  = f.pid ^ 8'($urandom_range(255, 1));
                default: f = can_frame_t'($bits(can_frame_t)'({$urandom, $urandom, $urandom}));
            endcase
        end else begin
            func = (pick < 96) ? FUNC_START : FUNC_UNUSED;
        end
    endtask

    task automatic run_random(int unsigned n_items);
        logic [1:0]  func;
        can_frame_t  f;
        bit          taken;
        repeat (n_items) begin
            random_item(func, f);
            send_item(func, f, taken);
        end
    endtask

    // finish any open round, then let the pipeline empty
    task automatic close_phase();
        while (sb.busy) begin
            if (sb.cfg.response_id_min <= sb.cfg.response_id_max)
                send_frame(sb.cfg.response_id_min, 4'd8, 8'd2, MODE01_RESPONSE,
                           sb.awaited_pid(), 8'h00, 8'h00);
            else
                send_cmd(FUNC_TICK);
        end
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_directed();
        send_cmd(FUNC_TICK);
        send_frame(29'd2024, 4'd8, 8'd4, MODE01_RESPONSE, 8'h0C, 8'hFF, 8'hFF);
        send_cmd(FUNC_UNUSED);
        send_cmd(FUNC_START);
        send_cmd(FUNC_START);
        send_cmd(FUNC_UNUSED);
        // rpm at its maximum, lowest accepted id
        send_frame(29'd2024, 4'd8, 8'd4, MODE01_RESPONSE, 8'h0C, 8'hFF, 8'hFF);
        send_frame(29'd2024, 4'd8, 8'd3, 8'h40, 8'h0D, 8'h11, 8'h22);
        send_frame(29'd2024, 4'd3, 8'd3, MODE01_RESPONSE, 8'h0D, 8'h11, 8'h22);
        send_frame(29'd2032, 4'd8, 8'd3, MODE01_RESPONSE, 8'h0D, 8'h11, 8'h22);
        send_frame(29'd2023, 4'd8, 8'd3, MODE01_RESPONSE, 8'h0D, 8'h11, 8'h22);
        send_frame(29'd2025, 4'd8, 8'd3, MODE01_RESPONSE, 8'h0C, 8'h11, 8'h22);
        // speed, highest accepted id, short frame
        send_frame(29'd2031, 4'd4, 8'd3, MODE01_RESPONSE, 8'h0D, 8'hFF, 8'hAA);
        // coolant at its minimum, length code above 8
        send_frame(29'd2027, 4'd15, 8'd255, MODE01_RESPONSE, 8'h05, 8'h00, 8'hFF);
        send_cmd(FUNC_TICK);
        send_cmd(FUNC_TICK);
        // MIL answered with a too-short payload
        send_frame(29'd2026, 4'd8, 8'd2, MODE01_RESPONSE, 8'h01, 8'hFF, 8'hFF);
        send_cmd(FUNC_START);
        send_frame(29'd2026, 4'd8, 8'd0, MODE01_RESPONSE, 8'h0C, 8'h12, 8'h34);
        send_cmd(FUNC_TICK);
        send_cmd(FUNC_TICK);
        send_frame(29'd2028, 4'd8, 8'd3, MODE01_RESPONSE, 8'h05, 8'hFF, 8'h00);
        send_frame(29'd2029, 4'd5, 8'd4, MODE01_RESPONSE, 8'h42, 8'hFF, 8'hFF);
        send_frame(29'd2030, 4'd8, 8'd3, MODE01_RESPONSE, 8'h01, 8'h80, 8'h00);
        send_cmd(FUNC_START);
        // rpm from a four-byte frame: byte B ignored
        send_frame(29'd2024, 4'd4, 8'd3, MODE01_RESPONSE, 8'h0C, 8'h12, 8'h34);
    endtask

    initial begin
        logic [ID_W-1:0] id_lo;
        int unsigned     n_failed;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apb_write(REG_TIMEOUT, 32'd2);
        run_directed();
        close_phase();

        write_config('0, '0, ID_MAX, 16'd1);
        run_random(160);
        close_phase();

        send_idle_pct = 58;
        id_lo = ID_W'($urandom);
        write_config(ID_MAX, id_lo, id_lo, 16'hFFFF);
        run_random(160);
        close_phase();

        send_idle_pct = 0;
        stall_pct     = 58;
        id_lo = ID_W'($urandom_range(ID_MAX - 600));
        write_config(ID_W'($urandom), id_lo, id_lo + ID_W'($urandom_range(500)),
                     TICK_W'($urandom_range(12, 2)));
        run_random(160);
        close_phase();

        send_idle_pct = 12;
        stall_pct     = 12;
        write_config(ID_W'($urandom), ID_MAX, ID_MAX, 16'd4);
        run_random(160);
        close_phase();

        // empty id window: rounds only end by timeout
        send_idle_pct = 0;
        stall_pct     = 0;
        write_config(REQ_ID_RESET, 29'd1000, 29'd10, 16'd3);
        run_random(160);
        close_phase();

        n_failed = sb.n_errors + sb.pending_q.size();
        $display("Sent %0d transfers over six register settings: %0d rounds, %0d updates,",
                 n_sent, sb.n_rounds, sb.n_updates);
        $display("%0d results checked, %0d failures", sb.n_checked, n_failed);
        if (n_failed == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
